/* rtl/adsr_enveloped_oscillator_top_assert.svh */
// Assertion macros for the enveloped oscillator.
// Used by adsr_enveloped_oscillator_top; expects clock and reset in scope.
`ifndef ADSR_ENVELOPED_OSCILLATOR_TOP_ASSERT_SVH
`define ADSR_ENVELOPED_OSCILLATOR_TOP_ASSERT_SVH

// The condition must never hold outside reset.
`define ADSR_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ADSR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/adsr_pkg.sv */
// Package for the enveloped oscillator: widths, codes and the sine table.
// No dependencies.
package adsr_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int SINE_TABLE_BITS = 8;
   localparam int TAB_LEN         = 1 << SINE_TABLE_BITS;
   localparam int FRAC            = 23;
   localparam int LEN_W           = 24;
   localparam int LEVEL_W         = 16;
   localparam int ENV_W           = 40;
   localparam int DVD_W           = LEVEL_W + FRAC;
   localparam logic [ENV_W-1:0] ENV_MAX = ENV_W'(64'd65535 << FRAC);

   localparam int FULL_W  = SAMPLE_BITS - 1;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = (FULL_W > 16) ? FULL_W : 16;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MAG_W   = PROD_W - 32;
   localparam longint unsigned FULL_VAL = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam longint unsigned LIM_VAL  = (FULL_VAL > 64'd32767) ? 64'd32767 : FULL_VAL;

   // Register indexes.
   localparam logic [3:0] REG_ATTACK  = 4'd0;
   localparam logic [3:0] REG_DECAY   = 4'd1;
   localparam logic [3:0] REG_HOLD    = 4'd2;
   localparam logic [3:0] REG_RELEASE = 4'd3;
   localparam logic [3:0] REG_PEAK    = 4'd4;
   localparam logic [3:0] REG_SUSTAIN = 4'd5;
   localparam logic [3:0] REG_STEP    = 4'd6;
   localparam logic [3:0] REG_SHAPE   = 4'd7;

   // Wave codes.
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_SAW      = 2'd2;
   localparam logic [1:0] WAVE_PULSE    = 2'd3;

   // Envelope stages.
   localparam logic [2:0] STG_IDLE    = 3'd0;
   localparam logic [2:0] STG_ATTACK  = 3'd1;
   localparam logic [2:0] STG_DECAY   = 3'd2;
   localparam logic [2:0] STG_SUSTAIN = 3'd3;
   localparam logic [2:0] STG_RELEASE = 3'd4;

   typedef logic [15:0] sine_tab_type [TAB_LEN];

   // Quarter-wave sine built from a fixed-point Taylor series at elaboration.
   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      longint unsigned one;
      longint unsigned half_pi;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned p;
      one     = 64'd1 << 30;
      half_pi = 64'd1686629713;
      for (int j = 0; j < TAB_LEN; j++) begin
         x  = ((2 * longint'(j) + 1) * half_pi) >> (SINE_TABLE_BITS + 1);
         x2 = (x * x) >> 30;
         t  = one;
         for (int k = 0; k < 5; k++) begin
            p = (x2 * t) >> 30;
            case (k)
               0:       t = one - p / 110;
               1:       t = one - p / 72;
               2:       t = one - p / 42;
               3:       t = one - p / 20;
               default: t = one - p / 6;
            endcase
         end
         t = (x * t) >> 30;
         tab[j] = 16'((t * 32767 + (one >> 1)) >> 30);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

   // First stage with a non-empty phase at or after from; idle if none.
   function automatic logic [2:0] first_stage(input logic [2:0] from,
                                              input logic [LEN_W-1:0] l1,
                                              input logic [LEN_W-1:0] l2,
                                              input logic [LEN_W-1:0] l3,
                                              input logic [LEN_W-1:0] l4);
      logic [2:0] res;
      res = STG_IDLE;
      if (from <= STG_RELEASE && l4 != '0) res = STG_RELEASE;
      if (from <= STG_SUSTAIN && l3 != '0) res = STG_SUSTAIN;
      if (from <= STG_DECAY && l2 != '0)   res = STG_DECAY;
      if (from <= STG_ATTACK && l1 != '0)  res = STG_ATTACK;
      return res;
   endfunction

endpackage

/* rtl/adsr_enveloped_oscillator_top.sv */
// Enveloped oscillator: one signed sample per accepted item while the note has a live stage;
// an item that starts a note runs three 39-step ramp divisions before its sample.
// One item is in flight at a time; the input stalls until the sample has been taken.
// A shared 33x16 multiplier is used twice per sample; a restoring divider makes the ramps.
// Reset (synchronous, active high) restores the register defaults and idles the note.
module adsr_enveloped_oscillator_top import adsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_start_note,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_sample_out,
   output logic                     rsp_last_sample,
   input  logic                     csr_wr_en,
   input  logic [3:0]               csr_index,
   input  logic [31:0]              csr_wdata
);

`include "adsr_enveloped_oscillator_top_assert.svh"

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_WAVE = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [5:0] DIV_STEPS = 6'(DVD_W);

   // Configuration registers.
   logic [LEN_W-1:0]   attack_len_ff, decay_len_ff, hold_len_ff, release_len_ff;
   logic [LEVEL_W-1:0] peak_ff, sustain_ff;
   logic [31:0]        step_ff;
   logic [17:0]        shape_ff;

   // Note state.
   logic [2:0]        st_ff, st_in;
   logic [2:0]        stage_ff, stage_in;
   logic [31:0]       phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [ENV_W-1:0]  env_ff, env_in;
   logic [ENV_W-1:0]  ramp0_ff, ramp0_in, ramp1_ff, ramp1_in, ramp2_ff, ramp2_in;
   logic              decay_neg_ff, decay_neg_in;

   // Divider.
   logic [1:0]        sel_ff, sel_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [LEN_W:0]    rem_ff, rem_in;

   // Sample path.
   logic [15:0]       aw_ff, aw_in;
   logic              wneg_ff, wneg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       sample_ff, sample_in;
   logic              last_ff, last_in;

   logic              accept;
   logic [1:0]        load_sel;
   logic [DVD_W-1:0]  load_dvd;
   logic [LEN_W-1:0]  load_dvs;
   logic [LEN_W-1:0]  cur_dvs;
   logic [LEN_W:0]    trial;
   logic [LEN_W:0]    rem_step;
   logic [DVD_W-1:0]  quot_step;
   logic [ENV_W-1:0]  div_res;
   logic [LEVEL_W:0]  lvl_diff;
   logic [LEVEL_W-1:0] lvl_abs;
   logic signed [17:0] wave;
   logic [15:0]       uph;
   logic [15:0]       tab_val;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0] rounded;
   logic [MAG_W-1:0]  mag;
   logic [15:0]       sat;
   logic signed [ENV_W+1:0] env_next;
   logic [LEN_W-1:0]  count_next;
   logic [LEN_W-1:0]  cur_len;
   logic [2:0]        enter_stage;
   logic [2:0]        start_stage;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || rsp_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = sample_ff;
   assign rsp_last_sample = last_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= '0;
         decay_len_ff   <= '0;
         hold_len_ff    <= '0;
         release_len_ff <= '0;
         peak_ff        <= 16'd65535;
         sustain_ff     <= 16'd32768;
         step_ff        <= '0;
         shape_ff       <= 18'd131072;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ATTACK:  attack_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_DECAY:   decay_len_ff   <= csr_wdata[LEN_W-1:0];
            REG_HOLD:    hold_len_ff    <= csr_wdata[LEN_W-1:0];
            REG_RELEASE: release_len_ff <= csr_wdata[LEN_W-1:0];
            REG_PEAK:    peak_ff        <= csr_wdata[LEVEL_W-1:0];
            REG_SUSTAIN: sustain_ff     <= csr_wdata[LEVEL_W-1:0];
            REG_STEP:    step_ff        <= csr_wdata;
            REG_SHAPE:   shape_ff       <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // Ramp division operands: attack uses the peak, decay the level gap,
   // release the sustain level.
   assign lvl_diff = {1'b0, peak_ff} - {1'b0, sustain_ff};
   assign lvl_abs  = lvl_diff[LEVEL_W] ? LEVEL_W'(-lvl_diff) : lvl_diff[LEVEL_W-1:0];
   assign load_sel = (st_ff == ST_IDLE) ? 2'd0 : sel_ff + 2'd1;

   always_comb begin
      case (load_sel)
         2'd0:    begin load_dvd = {peak_ff, FRAC'(0)};    load_dvs = attack_len_ff;  end
         2'd1:    begin load_dvd = {lvl_abs, FRAC'(0)};    load_dvs = decay_len_ff;   end
         default: begin load_dvd = {sustain_ff, FRAC'(0)}; load_dvs = release_len_ff; end
      endcase
      case (sel_ff)
         2'd0:    cur_dvs = attack_len_ff;
         2'd1:    cur_dvs = decay_len_ff;
         default: cur_dvs = release_len_ff;
      endcase
   end

   // One restoring division step per cycle.
   assign trial     = {rem_ff[LEN_W-1:0], quot_ff[DVD_W-1]} - {1'b0, cur_dvs};
   assign rem_step  = trial[LEN_W] ? {rem_ff[LEN_W-1:0], quot_ff[DVD_W-1]} : trial;
   assign quot_step = {quot_ff[DVD_W-2:0], ~trial[LEN_W]};
   assign div_res   = (cur_dvs == '0) ? '0 : ENV_W'(quot_step);

   // Wave value, unit 32768.
   assign uph     = phase_ff[31:16];
   assign tab_idx = phase_ff[29 -: SINE_TABLE_BITS];
   assign tab_val = SINE_TAB[phase_ff[30] ? SINE_TABLE_BITS'(TAB_LEN - 1) - tab_idx : tab_idx];

   always_comb begin
      case (shape_ff[1:0])
         WAVE_SINE: begin
            wave = phase_ff[31] ? -$signed({2'b00, tab_val}) : $signed({2'b00, tab_val});
         end
         WAVE_TRIANGLE: begin
            wave = uph[15] ? $signed({2'b00, uph[14:0], 1'b0}) - 18'sd32768
                           : 18'sd32768 - $signed({2'b00, uph[14:0], 1'b0});
         end
         WAVE_SAW: wave = $signed({2'b00, uph}) - 18'sd32768;
         default:  wave = (uph < shape_ff[17:2]) ? 18'sd32768 : -18'sd32768;
      endcase
   end

   // Shared multiplier: envelope times wave, then times full scale.
   assign mul_a   = (st_ff == ST_MUL1) ? MUL_A_W'(env_ff[38:7]) : prod_ff[15 +: MUL_A_W];
   assign mul_b   = (st_ff == ST_MUL1) ? MUL_B_W'(aw_ff) : MUL_B_W'(FULL_VAL);
   assign rounded = prod_ff + (PROD_W'(1) << 31);
   assign mag     = rounded[PROD_W-1:32];
   assign sat     = (mag > MAG_W'(LIM_VAL)) ? 16'(LIM_VAL) : mag[15:0];

   // Envelope and phase advance after each sample.
   always_comb begin
      case (stage_ff)
         STG_ATTACK:  cur_len = attack_len_ff;
         STG_DECAY:   cur_len = decay_len_ff;
         STG_SUSTAIN: cur_len = hold_len_ff;
         STG_RELEASE: cur_len = release_len_ff;
         default:     cur_len = '0;
      endcase
      case (stage_ff)
         STG_ATTACK:  env_next = $signed({2'b00, env_ff}) + $signed({2'b00, ramp0_ff});
         STG_DECAY:   env_next = decay_neg_ff ? $signed({2'b00, env_ff}) - $signed({2'b00, ramp1_ff})
                                              : $signed({2'b00, env_ff}) + $signed({2'b00, ramp1_ff});
         STG_RELEASE: env_next = $signed({2'b00, env_ff}) - $signed({2'b00, ramp2_ff});
         default:     env_next = $signed({2'b00, env_ff});
      endcase
   end

   assign count_next  = count_ff + LEN_W'(1);
   assign enter_stage = first_stage(stage_ff + 3'd1, attack_len_ff, decay_len_ff,
                                    hold_len_ff, release_len_ff);
   assign start_stage = first_stage(STG_ATTACK, attack_len_ff, decay_len_ff,
                                    hold_len_ff, release_len_ff);

   always_comb begin
      st_in        = st_ff;
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      env_in       = env_ff;
      ramp0_in     = ramp0_ff;
      ramp1_in     = ramp1_ff;
      ramp2_in     = ramp2_ff;
      decay_neg_in = decay_neg_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      aw_in        = aw_ff;
      wneg_in      = wneg_ff;
      prod_in      = prod_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_start_note) begin
                  // A new note: work out the three ramp steps first.
                  decay_neg_in = !lvl_diff[LEVEL_W] && (lvl_diff != '0);
                  phase_in     = '0;
                  sel_in       = 2'd0;
                  cnt_in       = DIV_STEPS;
                  quot_in      = load_dvd;
                  rem_in       = '0;
                  st_in        = ST_DIV;
               end else if (stage_ff != STG_IDLE) begin
                  st_in = ST_WAVE;
               end
            end
         end
         ST_DIV: begin
            quot_in = quot_step;
            rem_in  = rem_step;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               case (sel_ff)
                  2'd0:    ramp0_in = div_res;
                  2'd1:    ramp1_in = div_res;
                  default: ramp2_in = div_res;
               endcase
               if (sel_ff == 2'd2) begin
                  stage_in = start_stage;
                  count_in = '0;
                  case (start_stage)
                     STG_ATTACK: env_in = '0;
                     STG_DECAY:  env_in = ENV_W'({peak_ff, FRAC'(0)});
                     default:    env_in = ENV_W'({sustain_ff, FRAC'(0)});
                  endcase
                  st_in = (start_stage != STG_IDLE) ? ST_WAVE : ST_IDLE;
               end else begin
                  sel_in  = load_sel;
                  cnt_in  = DIV_STEPS;
                  quot_in = load_dvd;
                  rem_in  = '0;
               end
            end
         end
         ST_WAVE: begin
            wneg_in = wave[17];
            aw_in   = wave[17] ? 16'(-wave) : wave[15:0];
            st_in   = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in = PROD_W'(mul_a * mul_b);
            st_in   = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in = PROD_W'(mul_a * mul_b);
            st_in   = ST_OUT;
         end
         ST_OUT: begin
            sample_in = wneg_ff ? -sat : sat;
            phase_in  = phase_ff + step_ff;
            if (env_next < 0) begin
               env_in = '0;
            end else if (env_next > $signed({2'b00, ENV_MAX})) begin
               env_in = ENV_MAX;
            end else begin
               env_in = env_next[ENV_W-1:0];
            end
            count_in = count_next;
            stage_in = stage_ff;
            if (count_next >= cur_len || count_next == '0) begin
               stage_in = enter_stage;
               count_in = '0;
               case (enter_stage)
                  STG_DECAY:   env_in = ENV_W'({peak_ff, FRAC'(0)});
                  STG_SUSTAIN: env_in = ENV_W'({sustain_ff, FRAC'(0)});
                  STG_RELEASE: env_in = ENV_W'({sustain_ff, FRAC'(0)});
                  default: ;
               endcase
               last_in = (enter_stage == STG_IDLE);
            end else begin
               last_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            st_in        = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         stage_ff     <= STG_IDLE;
         phase_ff     <= '0;
         count_ff     <= '0;
         env_ff       <= '0;
         ramp0_ff     <= '0;
         ramp1_ff     <= '0;
         ramp2_ff     <= '0;
         decay_neg_ff <= 1'b0;
         sel_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         stage_ff     <= stage_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         env_ff       <= env_in;
         ramp0_ff     <= ramp0_in;
         ramp1_ff     <= ramp1_in;
         ramp2_ff     <= ramp2_in;
         decay_neg_ff <= decay_neg_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      aw_ff     <= aw_in;
      wneg_ff   <= wneg_in;
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
      last_ff   <= last_in;
   end

   // The envelope never leaves its clamped range.
   `ADSR_ASSERT_NEVER(env_in_range, env_ff > ENV_MAX, "envelope above maximum")
   // A new sample only appears right after the output step.
   `ADSR_ASSERT_IMPLY(rsp_from_out, $rose(rsp_valid_ff), $past(st_ff) == ST_OUT,
                      "sample raised outside output step")
   // A flagged final sample leaves the note idle until restarted.
   `ADSR_ASSERT_IMPLY(last_idles, rsp_valid_ff && last_ff && st_ff == ST_IDLE,
                      stage_ff == STG_IDLE, "note still running after last sample")

endmodule
